// ----- src/brf_pkg.sv -----
// Shared types and constants for the byte ring FIFO.
package brf_pkg;

   localparam int SIZE_W  = 11;
   localparam int LEVEL_W = 11;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAN = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] write_byte;
      logic [6:0] request_count;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               data_valid;
      logic [7:0]         read_byte;
      logic               last;
      logic [LEVEL_W-1:0] fill_level;
      logic [LEVEL_W-1:0] free_space;
   } rsp_type;

   typedef struct packed {
      logic               last;
      logic [LEVEL_W-1:0] fill_level;
      logic [LEVEL_W-1:0] free_space;
   } rd_meta_type;

endpackage

// ----- src/byte_ring_fifo_top.sv -----
// Top level of the byte ring FIFO: size register, capacity and block wiring.
//
// Use: items arrive on req_valid/req_ready with req_item (kind, write_byte,
// request_count); results leave on rsp_valid/rsp_ready with rsp_item.
// A write item gives one result, in the cycle after acceptance, and a new
// item may be taken every cycle while the receiver keeps up.
// A read burst of n bytes gives n results, the last one flagged: the first
// byte passes the burst state, the store read and the result queue; the rest
// follow one per cycle while the receiver keeps up, set by the single read
// port of the byte store. The next item waits until the last byte is queued.
// A read of an empty FIFO and a clean item give one result each.
// csr_we/csr_wdata write the requested size; the capacity becomes the next
// power of two (at most DEPTH) and the FIFO empties. Write only when idle.
// Reset empties the FIFO and sets the size to 1024; no clearing pass.
// When the receiver stalls, results collect in a two-entry queue and the
// block stops taking items or issuing reads until room returns.
module byte_ring_fifo_top #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  brf_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output brf_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [10:0]      csr_wdata
);

   import brf_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = ADDR_W + 1;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [PTR_W-1:0]  cap;

   logic              q_enq;
   rsp_type           q_item;
   logic [1:0]        q_count;
   logic              q_deq;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        mem_rdata;

   assign size_in = csr_we ? csr_wdata : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // smallest power of two covering the size, capped at DEPTH
   always_comb begin
      cap = PTR_W'(1);
      for (int i = 1; i <= SIZE_W; i++) begin
         if (i <= ADDR_W && size_ff > (SIZE_W'(1) << (i - 1))) begin
            cap = PTR_W'(1) << i;
         end
      end
   end

   brf_ctrl #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_we),
      .cap       (cap),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_count   (q_count),
      .q_deq     (q_deq),
      .enq_valid (q_enq),
      .enq_item  (q_item),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   brf_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   brf_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (q_enq),
      .enq_item  (q_item),
      .count     (q_count),
      .deq       (q_deq),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTHESIS
   a_no_q_overflow: assert property (@(posedge clock) disable iff (reset)
      q_enq |-> (q_count != 2'd2 || q_deq))
      else $error("result queue overflow");

   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.accepted && rsp_item.data_valid))
      else $error("item both stored and read");

   a_nodata_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.data_valid) |-> rsp_item.last)
      else $error("data-less item not marked last");

   a_no_write_read: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> !mem_we)
      else $error("store written during a burst");
`endif

endmodule

// ----- src/brf_store.sv -----
// Byte store: one write port, one read port with registered read data.
module brf_store #(
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [2**ADDR_W];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/brf_rsp_q.sv -----
// Two-entry result queue in front of the response channel.
module brf_rsp_q (
   input  logic            clock,
   input  logic            reset,
   input  logic            enq_valid,
   input  brf_pkg::rsp_type enq_item,
   output logic [1:0]      count,
   output logic            deq,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output brf_pkg::rsp_type rsp_item
);

   import brf_pkg::*;

   rsp_type    ent_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_item  = ent_ff[rd_ptr_ff];
   assign deq       = rsp_valid && rsp_ready;
   assign count     = count_ff;

   always_comb begin
      count_in  = count_ff + {1'b0, enq_valid} - {1'b0, deq};
      wr_ptr_in = wr_ptr_ff ^ enq_valid;
      rd_ptr_in = rd_ptr_ff ^ deq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_valid) begin
         ent_ff[wr_ptr_ff] <= enq_item;
      end
   end

endmodule

// ----- src/brf_ctrl.sv -----
// Pointer control and burst sequencer around the byte store.
module brf_ctrl #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64,
   localparam int ADDR_W   = $clog2(DEPTH),
   localparam int PTR_W    = ADDR_W + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic [PTR_W-1:0]  cap,
   input  logic              req_valid,
   output logic              req_ready,
   input  brf_pkg::req_type  req_item,
   input  logic [1:0]        q_count,
   input  logic              q_deq,
   output logic              enq_valid,
   output brf_pkg::rsp_type  enq_item,
   output logic              mem_we,
   output logic [ADDR_W-1:0] mem_waddr,
   output logic [7:0]        mem_wdata,
   output logic              mem_re,
   output logic [ADDR_W-1:0] mem_raddr,
   input  logic [7:0]        mem_rdata
);

   import brf_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_BURST = 1'b1;
   localparam logic [6:0] BURST_MAX = 7'(MAX_BURST);

   logic              state_ff, state_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [6:0]        left_ff, left_in;
   logic              rd_pend_ff, rd_pend_in;
   rd_meta_type       meta_ff, meta_in;

   logic [PTR_W-1:0]  fill;
   logic [PTR_W-1:0]  fill_after;
   logic [PTR_W-1:0]  fill_dec;
   logic [PTR_W-1:0]  amask;
   logic [2:0]        used;
   logic              room;
   logic              acc_fire;
   logic              has_space;
   logic [6:0]        req_sat;
   logic [PTR_W+6:0]  fill_w;
   logic [PTR_W+6:0]  req_w;
   logic [6:0]        take_n;

   always_comb begin
      fill       = wp_ff - rp_ff;
      amask      = cap - PTR_W'(1);
      has_space  = (fill < cap);
      fill_after = fill + PTR_W'(has_space);
      fill_dec   = fill - PTR_W'(1);
      used       = {1'b0, q_count} + {2'b0, rd_pend_ff} - {2'b0, q_deq};
      room       = (used < 3'd2);
      req_ready  = (state_ff == ST_IDLE) && !rd_pend_ff && room;
      acc_fire   = req_valid && req_ready;
      req_sat    = (req_item.request_count > BURST_MAX) ? BURST_MAX
                                                        : req_item.request_count;
      fill_w     = {7'b0, fill};
      req_w      = {{PTR_W{1'b0}}, req_sat};
      take_n     = (fill_w < req_w) ? fill_w[6:0] : req_sat;
   end

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      left_in    = left_ff;
      meta_in    = meta_ff;
      enq_valid  = 1'b0;
      enq_item   = '0;
      mem_we     = 1'b0;
      mem_waddr  = wp_ff[ADDR_W-1:0] & amask[ADDR_W-1:0];
      mem_wdata  = req_item.write_byte;
      mem_re     = 1'b0;
      mem_raddr  = rp_ff[ADDR_W-1:0] & amask[ADDR_W-1:0];

      if (rd_pend_ff) begin
         enq_valid           = 1'b1;
         enq_item.data_valid = 1'b1;
         enq_item.read_byte  = mem_rdata;
         enq_item.last       = meta_ff.last;
         enq_item.fill_level = meta_ff.fill_level;
         enq_item.free_space = meta_ff.free_space;
      end else if (acc_fire) begin
         case (req_item.kind)
            KIND_WRITE: begin
               enq_valid           = 1'b1;
               enq_item.accepted   = has_space;
               enq_item.last       = 1'b1;
               enq_item.fill_level = LEVEL_W'(fill_after);
               enq_item.free_space = LEVEL_W'(cap - fill_after);
               mem_we              = has_space;
               wp_in               = fill_after + rp_ff;
            end
            KIND_READ: begin
               if (take_n == 7'd0) begin
                  enq_valid           = 1'b1;
                  enq_item.last       = 1'b1;
                  enq_item.fill_level = LEVEL_W'(fill);
                  enq_item.free_space = LEVEL_W'(cap - fill);
               end else begin
                  state_in = ST_BURST;
                  left_in  = take_n;
               end
            end
            KIND_CLEAN: begin
               enq_valid           = 1'b1;
               enq_item.last       = 1'b1;
               enq_item.free_space = LEVEL_W'(cap);
               wp_in               = '0;
               rp_in               = '0;
            end
            default: begin
            end
         endcase
      end

      if (state_ff == ST_BURST && room) begin
         mem_re             = 1'b1;
         rp_in              = rp_ff + PTR_W'(1);
         left_in            = left_ff - 7'd1;
         meta_in.last       = (left_ff == 7'd1);
         meta_in.fill_level = LEVEL_W'(fill_dec);
         meta_in.free_space = LEVEL_W'(cap - fill_dec);
         if (left_ff == 7'd1) begin
            state_in = ST_IDLE;
         end
      end

      if (clear) begin
         wp_in    = '0;
         rp_in    = '0;
         state_in = ST_IDLE;
      end
   end

   assign rd_pend_in = mem_re && !clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wp_ff      <= '0;
         rp_ff      <= '0;
         left_ff    <= 7'd0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         left_ff    <= left_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
   end

endmodule

// ----- tb/tb_byte_ring_fifo_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_fifo_top: random traffic against a behavioural FIFO model.
module tb_byte_ring_fifo_top;
   import brf_pkg::*;

   localparam int RING_DEPTH    = 1024;
   localparam int BURST_MAX     = 64;
   localparam int IDLE_LIMIT    = 5000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 10;
   localparam int PRINT_MAX     = 50;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_item  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_item;
   logic        csr_we    = 1'b0;
   logic [10:0] csr_wdata = '0;

   logic [7:0]  ring_bytes [RING_DEPTH];
   logic [10:0] wr_ptr, rd_ptr, ring_cap;
   rsp_type     due_rsp_q [$];
   req_type     pending_q [$];

   int          items_queued = 0;
   int          items_taken  = 0;
   int          error_count  = 0;
   int          idle_cycles  = 0;
   logic        req_fired    = 1'b0;
   int          burst_left   = 0;
   int          gap_left     = 0;
   int          hold_left    = 0;
   int          stretch_left = 0;
   rx_mode_type rx_mode      = RX_OPEN;
   logic        long_hold_go = 1'b0;

   logic [10:0] size_plan   [7] = '{11'd3, 11'd64, 11'd2047, 11'd1, 11'd100, 11'd17, 11'd1024};
   int          budget_plan [7] = '{12, 30, 12, 8, 12, 10, 6};

   byte_ring_fifo_top #(
      .DEPTH     (RING_DEPTH),
      .MAX_BURST (BURST_MAX)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [10:0] ring_fill();
      return wr_ptr - rd_ptr;
   endfunction

   function automatic void push_result(logic acc, logic dv, logic [7:0] data, logic lst);
      rsp_type r;
      r.accepted   = acc;
      r.data_valid = dv;
      r.read_byte  = data;
      r.last       = lst;
      r.fill_level = ring_fill();
      r.free_space = ring_cap - ring_fill();
      due_rsp_q.push_back(r);
   endfunction

   function automatic void set_ring_size(logic [10:0] size);
      int c;
      c = 1;
      while (c < size && c * 2 <= RING_DEPTH)
         c = c * 2;
      ring_cap = 11'(c);
      wr_ptr   = '0;
      rd_ptr   = '0;
   endfunction

   function automatic void apply_fifo_op(req_type it);
      logic [10:0] amask;
      logic [9:0]  slot;
      logic [7:0]  data;
      int          want, fill, n;
      amask = ring_cap - 11'd1;
      case (it.kind)
         KIND_WRITE: begin
            if (ring_fill() < ring_cap) begin
               slot = 10'(wr_ptr & amask);
               ring_bytes[slot] = it.write_byte;
               wr_ptr = wr_ptr + 11'd1;
               push_result(1'b1, 1'b0, 8'h00, 1'b1);
            end else begin
               push_result(1'b0, 1'b0, 8'h00, 1'b1);
            end
         end
         KIND_READ: begin
            want = (it.request_count > BURST_MAX) ? BURST_MAX : int'(it.request_count);
            fill = ring_fill();
            n    = (fill < want) ? fill : want;
            if (n == 0)
               push_result(1'b0, 1'b0, 8'h00, 1'b1);
            for (int i = 0; i < n; i++) begin
               slot   = 10'(rd_ptr & amask);
               data   = ring_bytes[slot];
               rd_ptr = rd_ptr + 11'd1;
               push_result(1'b0, 1'b1, data, i == n - 1);
            end
         end
         KIND_CLEAN: begin
            wr_ptr = '0;
            rd_ptr = '0;
            push_result(1'b0, 1'b0, 8'h00, 1'b1);
         end
         default: ;
      endcase
   endfunction

   task automatic flag_error(string msg);
      if (error_count < PRINT_MAX)
         $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [10:0] got, logic [10:0] want);
      if (got !== want)
         flag_error($sformatf("%s got %0d, expected %0d", name, got, want));
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (due_rsp_q.size() == 0) begin
         flag_error($sformatf("result with none due: %p", got));
         return;
      end
      want = due_rsp_q.pop_front();
      check_field("accepted",   got.accepted,   want.accepted);
      check_field("data_valid", got.data_valid, want.data_valid);
      check_field("read_byte",  got.read_byte,  want.read_byte);
      check_field("last",       got.last,       want.last);
      check_field("fill_level", got.fill_level, want.fill_level);
      check_field("free_space", got.free_space, want.free_space);
   endtask

   // acceptance, prediction, checking and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
         idle_cycles = 0;
      end else begin
         req_fired <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            apply_fifo_op(req_item);
            items_taken++;
         end
         if (rsp_valid && rsp_ready)
            check_result(rsp_item);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // item driver: bursts and gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_item  <= pending_q.pop_front();
            req_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 8);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: stall pattern plus an occasional long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_go || hold_left > 0) begin
         if (long_hold_go) begin
            hold_left    = LONG_HOLD;
            long_hold_go = 1'b0;
         end else begin
            hold_left--;
         end
         rsp_ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            stretch_left = $urandom_range(8, 60);
         end else begin
            stretch_left--;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic queue_item(logic [1:0] kind, logic [7:0] wb, logic [6:0] cnt);
      req_type it;
      it.kind          = kind;
      it.write_byte    = wb;
      it.request_count = cnt;
      pending_q.push_back(it);
      items_queued++;
   endtask

   // fill runs each followed by a read, or now and then a clean or spare kind
   task automatic queue_random_items(int budget, int run_max);
      int made, run;
      made = 0;
      while (made < budget) begin
         run = $urandom_range(0, run_max);
         for (int k = 0; k < run && made < budget; k++) begin
            queue_item(KIND_WRITE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            made++;
         end
         case ($urandom_range(0, 9))
            0: begin
               queue_item(KIND_CLEAN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
               made++;
            end
            1: queue_item(KIND_SPARE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            2, 3: begin
               queue_item(KIND_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
               made++;
            end
            default: begin
               queue_item(KIND_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(1, run + 1)));
               made++;
            end
         endcase
      end
   endtask

   task automatic write_size(logic [10:0] size);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= size;
      @(negedge clock);
      csr_we    <= 1'b0;
      set_ring_size(size);
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (items_taken != items_queued || due_rsp_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      set_ring_size(SIZE_RESET);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset size: empty reads, zero count, saturated burst, spare kind, clean
      queue_item(KIND_READ,  8'h00, 7'd64);
      queue_item(KIND_READ,  8'hFF, 7'd0);
      queue_item(KIND_WRITE, 8'h00, 7'd0);
      queue_item(KIND_WRITE, 8'hFF, 7'h7F);
      queue_item(KIND_WRITE, 8'hA5, 7'd0);
      queue_item(KIND_WRITE, 8'h5A, 7'd0);
      queue_item(KIND_READ,  8'h00, 7'd1);
      queue_item(KIND_READ,  8'h00, 7'd0);
      queue_item(KIND_SPARE, 8'hFF, 7'h7F);
      queue_item(KIND_READ,  8'h00, 7'h7F);
      queue_item(KIND_WRITE, 8'h3C, 7'd0);
      queue_item(KIND_WRITE, 8'hC3, 7'd0);
      queue_item(KIND_CLEAN, 8'h00, 7'd0);
      queue_item(KIND_READ,  8'h00, 7'd5);
      wait_drained();

      // size zero gives one byte of room: second write dropped
      write_size(11'd0);
      queue_item(KIND_WRITE, 8'h11, 7'd0);
      queue_item(KIND_WRITE, 8'h22, 7'd0);
      queue_item(KIND_READ,  8'h00, 7'd64);
      queue_item(KIND_WRITE, 8'h33, 7'd0);
      queue_item(KIND_CLEAN, 8'h00, 7'd0);
      queue_item(KIND_READ,  8'h00, 7'd2);
      wait_drained();

      size_plan[4] = 11'($urandom_range(5, 1000));
      foreach (size_plan[p]) begin
         write_size(size_plan[p]);
         if (size_plan[p] == 11'd2047) begin
            @(posedge clock);
            long_hold_go = 1'b1;
         end
         queue_random_items(budget_plan[p], (ring_cap + 2 > 66) ? 66 : ring_cap + 2);
         wait_drained();
      end

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/brf_pkg.sv
src/brf_store.sv
src/brf_rsp_q.sv
src/brf_ctrl.sv
src/byte_ring_fifo_top.sv
tb/tb_byte_ring_fifo_top.sv
